[sv/cdq_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types for the circular deque unit.
package cdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 11;
    localparam int DATA_W = 32;
    localparam int KIND_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    // Operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_QUERY      = KIND_W'(4);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;   // item accepted this cycle: update pointers, write, issue reads
        logic load;   // copy read data into the output register
    } cmd_t;

endpackage

[sv/cdq_ram.sv]
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports, read-before-write.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[sv/cdq_ctrl.sv]
`timescale 1ns / 1ps
// Controller: handshake sequencing and output valid for the deque.
module cdq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output cdq_pkg::cmd_t cmd
);

    cdq_pkg::state_t state_reg;
    cdq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cdq_pkg::ST_READ;
                end
            end
            cdq_pkg::ST_READ:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = cdq_pkg::ST_IDLE;
                end
            end
            default: state_next = cdq_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            cdq_pkg::ST_READ:
            begin
                cmd.load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Output register valid: set on load, cleared when the item is taken
    always_comb
    begin
        priority if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A load must follow an accepted item before the next one is taken
    a_take_then_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> !cmd.take)
        else $error("item taken while read still pending");

    // Loading never overwrites a result the receiver has not taken
    a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // A take is followed by the read phase, in which the load happens
    a_load_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (state_reg == cdq_pkg::ST_READ))
        else $error("no read phase after take");

endmodule

[sv/cdq_datapath.sv]
`timescale 1ns / 1ps
// Datapath: head/count pointers, ring store, forwarding and output register.
module cdq_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cdq_pkg::cmd_t                          cmd,
    input  logic                                   cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]              cfg_wdata,
    input  logic [cdq_pkg::KIND_W-1:0]             kind,
    input  logic signed [cdq_pkg::DATA_W-1:0]      value,
    output logic                                   ok,
    output logic signed [cdq_pkg::DATA_W-1:0]      front_value,
    output logic signed [cdq_pkg::DATA_W-1:0]      rear_value,
    output logic                                   empty_res,
    output logic                                   full_res
);

    localparam int IW = cdq_pkg::IDX_W;
    localparam int CW = cdq_pkg::CNT_W;
    localparam int DW = cdq_pkg::DATA_W;

    logic [cdq_pkg::CAP_W-1:0] capacity_reg;
    logic [IW-1:0]             head_reg;
    logic [IW-1:0]             head_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;

    logic [CW-1:0]             cap_eff;
    logic [IW-1:0]             head_dec;
    logic [IW-1:0]             head_inc;
    logic [CW-1:0]             inc_sum;
    logic [CW:0]               rear_sum;
    logic [IW-1:0]             rear_slot;
    logic [CW:0]               last_sum;
    logic [IW-1:0]             last_slot;
    logic                      can_push;
    logic                      can_pop;
    logic                      op_ok;

    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic [DW-1:0]             rd_front;
    logic [DW-1:0]             rd_rear;

    // Held between the accept cycle and the load cycle
    logic                      ok_pend_reg;
    logic                      empty_pend_reg;
    logic                      full_pend_reg;
    logic                      fwd_front_reg;
    logic                      fwd_rear_reg;
    logic [DW-1:0]             wdata_pend_reg;

    // Output register
    logic                      ok_reg;
    logic                      empty_reg;
    logic                      full_reg;
    logic [DW-1:0]             front_reg;
    logic [DW-1:0]             rear_reg;

    // Capacity clamped to 1..DEPTH
    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(capacity_reg) > 32'(cdq_pkg::DEPTH))
        begin
            cap_eff = CW'(cdq_pkg::DEPTH);
        end
        else
        begin
            cap_eff = CW'(capacity_reg);
        end
    end

    assign can_push = count_reg < cap_eff;
    assign can_pop  = count_reg != '0;

    // Ring arithmetic; sums stay below twice the capacity, one subtract wraps
    always_comb
    begin
        head_dec = (head_reg == '0) ? IW'(cap_eff - CW'(1)) : head_reg - IW'(1);
        inc_sum  = CW'(head_reg) + CW'(1);
        head_inc = (inc_sum >= cap_eff) ? '0 : IW'(inc_sum);
        rear_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        if (rear_sum >= (CW+1)'(cap_eff))
        begin
            rear_sum = rear_sum - (CW+1)'(cap_eff);
        end
        rear_slot = IW'(rear_sum);
    end

    // Operation decode
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = rear_slot;
        op_ok      = 1'b0;
        unique case (kind)
            cdq_pkg::KIND_PUSH_FRONT:
            begin
                if (can_push)
                begin
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    op_ok      = 1'b1;
                end
            end
            cdq_pkg::KIND_PUSH_REAR:
            begin
                if (can_push)
                begin
                    count_next = count_reg + CW'(1);
                    wr_en      = 1'b1;
                    op_ok      = 1'b1;
                end
            end
            cdq_pkg::KIND_POP_FRONT:
            begin
                if (can_pop)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                    op_ok      = 1'b1;
                end
            end
            cdq_pkg::KIND_POP_REAR:
            begin
                if (can_pop)
                begin
                    count_next = count_reg - CW'(1);
                    op_ok      = 1'b1;
                end
            end
            cdq_pkg::KIND_QUERY:
            begin
                op_ok = 1'b1;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // Slot of the rear element after the operation (meaningless when empty)
    always_comb
    begin
        last_sum = (CW+1)'(head_next) + (CW+1)'(count_next) - (CW+1)'(1);
        if (last_sum >= (CW+1)'(cap_eff))
        begin
            last_sum = last_sum - (CW+1)'(cap_eff);
        end
        last_slot = IW'(last_sum);
    end

    cdq_ram #(
        .WIDTH (DW),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (cmd.take && wr_en),
        .waddr   (wr_addr),
        .wdata   (value),
        .re      (cmd.take),
        .raddr_a (head_next),
        .raddr_b (last_slot),
        .rdata_a (rd_front),
        .rdata_b (rd_rear)
    );

    // Control state: capacity, head, count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cdq_pkg::CAP_RESET;
            head_reg     <= '0;
            count_reg    <= '0;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
            head_reg     <= '0;
            count_reg    <= '0;
        end
        else if (cmd.take)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Flags and write bypass for the load cycle
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ok_pend_reg    <= op_ok;
            empty_pend_reg <= count_next == '0;
            full_pend_reg  <= count_next == cap_eff;
            fwd_front_reg  <= wr_en && (wr_addr == head_next);
            fwd_rear_reg   <= wr_en && (wr_addr == last_slot);
            wdata_pend_reg <= value;
        end
    end

    // Output register; end values read as all ones when empty
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_reg    <= ok_pend_reg;
            empty_reg <= empty_pend_reg;
            full_reg  <= full_pend_reg;
            front_reg <= empty_pend_reg ? '1 : (fwd_front_reg ? wdata_pend_reg : rd_front);
            rear_reg  <= empty_pend_reg ? '1 : (fwd_rear_reg ? wdata_pend_reg : rd_rear);
        end
    end

    assign ok          = ok_reg;
    assign empty_res   = empty_reg;
    assign full_res    = full_reg;
    assign front_value = front_reg;
    assign rear_value  = rear_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_eff)
        else $error("element count above capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < IW'(cap_eff) || cap_eff == CW'(cdq_pkg::DEPTH))
        else $error("head outside ring");

    a_flags_track: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> (empty_pend_reg == (count_reg == '0))
                     && (full_pend_reg == (count_reg == cap_eff)))
        else $error("pending flags disagree with count");

endmodule

[sv/circular_deque_unit.sv]
`timescale 1ns / 1ps
// Top level: double-ended queue in a ring store with configurable capacity.
//
// Usage:
//   Input channel (in_valid/in_ready, kind, value) takes one operation per
//   item: push front, push rear, pop front, pop rear or query. The output
//   channel (out_valid/out_ready) returns one item per input item: ok, the
//   front and rear values after the operation (all ones when empty), and the
//   empty and full flags.
//   Each item is handled in an accept step, which updates the pointers and
//   writes the ring RAM, then a read step, which returns the RAM reads of
//   both ends through a single read-port pair into the output register and
//   raises out_valid; no new item is taken until the read step is done.
//   An accepted item's result sits in the output register, so the next item
//   is accepted while it waits; a receiver stall reaching into the following
//   item's read phase holds that item there with in_ready low.
//   Reset empties the deque and sets capacity to 1024; RAM contents are not
//   cleared (entries are only read after being written).
//   cfg_we writes the capacity (0 acts as 1, above the depth acts as the
//   depth) and empties the deque; write it only while the block is idle.
module circular_deque_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cdq_pkg::KIND_W-1:0]          kind,
    input  logic signed [cdq_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ok,
    output logic signed [cdq_pkg::DATA_W-1:0]   front_value,
    output logic signed [cdq_pkg::DATA_W-1:0]   rear_value,
    output logic                                empty_res,
    output logic                                full_res,
    input  logic                                cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]           cfg_wdata
);

    cdq_pkg::cmd_t cmd;

    // Sequencing: accept -> read -> output register
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Pointers, ring RAM and result registers
    cdq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .kind        (kind),
        .value       (value),
        .ok          (ok),
        .front_value (front_value),
        .rear_value  (rear_value),
        .empty_res   (empty_res),
        .full_res    (full_res)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for circular_deque_unit: random deque operations checked against a tracking model.
module tb_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 192;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    // kind codes the block must treat as no-ops
    localparam logic [cdq_pkg::KIND_W-1:0] KIND_UNUSED_FIRST = cdq_pkg::KIND_QUERY + 1'b1;
    localparam logic [cdq_pkg::KIND_W-1:0] KIND_UNUSED_LAST  = '1;

    typedef struct {
        logic [cdq_pkg::KIND_W-1:0] op;
        logic [cdq_pkg::DATA_W-1:0] word;
    } deque_op_t;

    typedef struct {
        logic                       ok;
        logic [cdq_pkg::DATA_W-1:0] front_word;
        logic [cdq_pkg::DATA_W-1:0] rear_word;
        logic                       is_empty;
        logic                       is_full;
    } deque_view_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [cdq_pkg::KIND_W-1:0]        kind = '0;
    logic signed [cdq_pkg::DATA_W-1:0] value = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic                              ok;
    logic signed [cdq_pkg::DATA_W-1:0] front_value;
    logic signed [cdq_pkg::DATA_W-1:0] rear_value;
    logic                              empty_res;
    logic                              full_res;
    logic                              cfg_we = 1'b0;
    logic [cdq_pkg::CAP_W-1:0]         cfg_wdata = '0;

    circular_deque_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .front_value (front_value),
        .rear_value  (rear_value),
        .empty_res   (empty_res),
        .full_res    (full_res),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Mirror of the deque: ring contents, front slot, element count, capacity
    logic [cdq_pkg::DATA_W-1:0] ring_mirror [0:cdq_pkg::DEPTH-1];
    int unsigned                front_idx = 0;
    int unsigned                held_count = 0;
    logic [cdq_pkg::CAP_W-1:0]  cap_reg = cdq_pkg::CAP_RESET;

    deque_op_t   op_backlog[$];
    deque_view_t expected_views[$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    bit  item_taken = 1'b0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_off = 0;
    int  pressure_runs = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;

    // capacity schedule after the reset phase: zero, one, and above-depth included
    int unsigned cap_plan [10] = '{0, 1, 2047, 2, 5, 16, 1024, 3, 64, 7};

    // Apply one operation to the mirror and return what the block should report.
    function automatic deque_view_t deque_apply(input logic [cdq_pkg::KIND_W-1:0] op,
                                                input logic [cdq_pkg::DATA_W-1:0] word);
        deque_view_t v;
        int unsigned lim;
        v.ok = 1'b0;
        lim = (cap_reg == '0) ? 1 :
              ((cap_reg > cdq_pkg::DEPTH) ? cdq_pkg::DEPTH : int'(cap_reg));
        if (front_idx >= lim)
            front_idx = 0;
        if (held_count > lim)
            held_count = lim;
        case (op)
            cdq_pkg::KIND_PUSH_FRONT:
                if (held_count < lim)
                begin
                    front_idx = (front_idx == 0) ? lim - 1 : front_idx - 1;
                    ring_mirror[front_idx] = word;
                    held_count++;
                    v.ok = 1'b1;
                end
            cdq_pkg::KIND_PUSH_REAR:
                if (held_count < lim)
                begin
                    ring_mirror[(front_idx + held_count) % lim] = word;
                    held_count++;
                    v.ok = 1'b1;
                end
            cdq_pkg::KIND_POP_FRONT:
                if (held_count != 0)
                begin
                    front_idx = (front_idx + 1) % lim;
                    held_count--;
                    v.ok = 1'b1;
                end
            cdq_pkg::KIND_POP_REAR:
                if (held_count != 0)
                begin
                    held_count--;
                    v.ok = 1'b1;
                end
            cdq_pkg::KIND_QUERY:
                v.ok = 1'b1;
            default:
                v.ok = 1'b0;
        endcase
        v.front_word = '1;
        v.rear_word = '1;
        if (held_count != 0)
        begin
            v.front_word = ring_mirror[front_idx];
            v.rear_word = ring_mirror[(front_idx + held_count - 1) % lim];
        end
        v.is_empty = (held_count == 0);
        v.is_full = (held_count == lim);
        return v;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [cdq_pkg::KIND_W-1:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return cdq_pkg::KIND_QUERY;
        if (r < 12)
            return cdq_pkg::KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? cdq_pkg::KIND_PUSH_FRONT : cdq_pkg::KIND_PUSH_REAR;
        return $urandom_range(0, 1) ? cdq_pkg::KIND_POP_FRONT : cdq_pkg::KIND_POP_REAR;
    endfunction

    function automatic logic [cdq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic [cdq_pkg::KIND_W-1:0] op,
                            input logic [cdq_pkg::DATA_W-1:0] word);
        deque_op_t t;
        t.op = op;
        t.word = word;
        op_backlog.push_back(t);
    endtask

    // Block until every queued item has been sent and answered, plus a margin.
    task automatic wait_idle();
        while (op_backlog.size() != 0 || expected_views.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Capacity write also empties the deque; only done with nothing in flight.
    task automatic set_capacity(input logic [cdq_pkg::CAP_W-1:0] cap);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_reg = cap;
        front_idx = 0;
        held_count = 0;
    endtask

    // Sender: new item or gap at the falling edge, held until taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || item_taken)
        begin
            item_taken = 1'b0;
            if (tx_gap != 0)
            begin
                in_valid <= 1'b0;
                tx_gap--;
            end
            else if (op_backlog.size() != 0)
            begin
                in_valid <= 1'b1;
                kind <= op_backlog[0].op;
                value <= op_backlog[0].word;
                tx_gap = tx_quiet ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
        if ($urandom_range(0, 149) == 0)
            tx_quiet = !tx_quiet;
    end

    // Input acceptance: predict the result at the moment the item is taken.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_views.push_back(deque_apply(kind, value));
            void'(op_backlog.pop_front());
            item_taken = 1'b1;
        end
    end

    // Receiver: random stalls, and twice a long hold-off so the block backs up.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off != 0)
        begin
            out_ready <= 1'b0;
            hold_off--;
        end
        else if (pressure_runs < 2 && results_seen >= 300 * (pressure_runs + 1) &&
                 op_backlog.size() >= 30)
        begin
            pressure_runs++;
            hold_off = 250;
            out_ready <= 1'b0;
        end
        else if (rx_gap != 0)
        begin
            out_ready <= 1'b0;
            rx_gap--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!rx_quiet && $urandom_range(0, 2) == 0)
                rx_gap = pick_gap();
        end
        if ($urandom_range(0, 149) == 0)
            rx_quiet = !rx_quiet;
    end

    // Result checker
    always @(posedge clk)
    begin
        deque_view_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_views.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected item: ok=%b front=%h rear=%h empty=%b full=%b",
                             ok, front_value, rear_value, empty_res, full_res);
            end
            else
            begin
                want = expected_views.pop_front();
                if (ok !== want.ok || front_value !== want.front_word ||
                    rear_value !== want.rear_word || empty_res !== want.is_empty ||
                    full_res !== want.is_full)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch at item %0d:", results_seen);
                        $display("  expected ok=%b front=%h rear=%h empty=%b full=%b",
                                 want.ok, want.front_word, want.rear_word,
                                 want.is_empty, want.is_full);
                        $display("  actual   ok=%b front=%h rear=%h empty=%b full=%b",
                                 ok, front_value, rear_value, empty_res, full_res);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int push_pct;
        int seg_left;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-state failures, signed extremes at both ends, unused kinds
        queue_op(cdq_pkg::KIND_QUERY, 32'h1234_5678);
        queue_op(cdq_pkg::KIND_POP_FRONT, 32'h0);
        queue_op(cdq_pkg::KIND_POP_REAR, 32'hFFFF_FFFF);
        queue_op(cdq_pkg::KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        queue_op(cdq_pkg::KIND_PUSH_REAR, 32'h8000_0000);
        queue_op(cdq_pkg::KIND_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_op(cdq_pkg::KIND_PUSH_REAR, 32'h0000_0000);
        queue_op(cdq_pkg::KIND_QUERY, 32'h0);
        queue_op(KIND_UNUSED_FIRST, 32'hA5A5_A5A5);
        queue_op(KIND_UNUSED_FIRST + 1'b1, 32'h5A5A_5A5A);
        queue_op(KIND_UNUSED_LAST, 32'hFFFF_FFFF);
        queue_op(cdq_pkg::KIND_POP_FRONT, 32'h0);
        queue_op(cdq_pkg::KIND_POP_REAR, 32'h0);
        queue_op(cdq_pkg::KIND_POP_FRONT, 32'h0);
        queue_op(cdq_pkg::KIND_POP_REAR, 32'h0);
        queue_op(cdq_pkg::KIND_POP_FRONT, 32'h0);
        queue_op(cdq_pkg::KIND_PUSH_REAR, 32'h0000_0001);
        queue_op(cdq_pkg::KIND_POP_REAR, 32'h0);

        // Random phases, one per capacity; push-heavy and pop-heavy stretches
        // alternate so both full and empty are reached at small capacities.
        foreach (cap_plan[p])
        begin
            set_capacity(cdq_pkg::CAP_W'(cap_plan[p]));
            push_pct = 25;
            seg_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (seg_left == 0)
                begin
                    push_pct = (push_pct > 50) ? 25 : 75;
                    seg_left = $urandom_range(8, 40);
                end
                seg_left--;
                queue_op(pick_op(push_pct), pick_word());
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
